// ===== rtl/rig_pkg.sv =====
// ----------------------------------------------------------------------------
// rig_pkg: shared types and constants for the reverse-in-groups unit
// Holds field widths, the default store depth, the sequencer states and the
// result record that travels through the output queue.
// ----------------------------------------------------------------------------
package rig_pkg;

	// Field widths
	localparam int VALUE_W = 32;
	localparam int GS_W    = 7;

	// Default depth of the group store
	localparam int DEF_MAX_GROUP = 64;

	// Sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} rig_state_t;

	// One result on its way to the output port
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               run_end;
		logic               seq_end;
	} rig_res_t;

endpackage

// ===== rtl/reverse_in_groups_unit.sv =====
// ----------------------------------------------------------------------------
// reverse_in_groups_unit: reverses a value stream in groups of group_size
// Values collect in a group store; a full group is read out newest first,
// a partial tail at the end of a sequence is read out in arrival order.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload
//  --------+-----------+------------------------------------------------------
//  s_*     | in        | tdata[31:0] value, tlast final_req
//  m_*     | out       | tdata[31:0] value_res, tuser run_end, tlast sequence_end
//  cfg_*   | in        | data[6:0] group_size (always ready)
//
//  An input request is taken while the sequencer is idle.
//  A request that closes a group or a sequence then reads n values out of the
//  store, one store read per cycle while the queue has room; input waits meanwhile.
//  The store is a single synchronous RAM; its read port sets the output rate.
//  A two-entry output queue keeps reads going while the output side stalls.
//  Reset clears the fill count and control state; the store needs no clearing.
//
module reverse_in_groups_unit
	import rig_pkg::*;
#(
	parameter int MAX_GROUP = DEF_MAX_GROUP
) (
	input  logic               clk,
	input  logic               arst_n,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
	input  logic               s_tlast,   // final_req
	// output stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,   // [31:0] value_res
	output logic               m_tuser,   // [0] run_end
	output logic               m_tlast,   // sequence_end
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [GS_W-1:0]    cfg_data   // [6:0] group_size
);

	localparam int AW    = $clog2(MAX_GROUP);
	localparam int CNT_W = $clog2(MAX_GROUP + 1);
	localparam logic [GS_W-1:0]  MAX_GS   = GS_W'(MAX_GROUP);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	rig_state_t state_q, state_d;

	logic [GS_W-1:0]  gs_q;
	logic [CNT_W-1:0] k_eff;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] n_new;
	logic [CNT_W-1:0] rem_q;
	logic [AW-1:0]    addr_q;
	logic             rev_q;
	logic             final_q;

	logic             in_acc;
	logic             do_emit;
	logic             rd_issue;
	logic             rd_last;

	logic             valid_s1;
	logic             run_end_s1;
	logic             seq_end_s1;
	logic [VALUE_W-1:0] rdata;

	rig_res_t         fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fcnt_q;
	logic [1:0]       occ;
	logic             push;
	logic             pop;
	logic             room;
	rig_res_t         head;

	// Configuration register, always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q <= GS_W'(1);
		end else if (cfg_valid) begin
			gs_q <= cfg_data;
		end
	end

	// Clamp the group size to 1..MAX_GROUP
	always_comb begin
		if (gs_q == '0) begin
			k_eff = CNT_ONE;
		end else if (gs_q > MAX_GS) begin
			k_eff = CNT_W'(MAX_GROUP);
		end else begin
			k_eff = CNT_W'(gs_q);
		end
	end

	assign n_new   = fill_q + CNT_ONE;
	assign in_acc  = s_tvalid && s_tready;
	assign do_emit = (n_new >= k_eff) || s_tlast;

	// Output queue occupancy, counting the read in flight
	assign pop  = m_tvalid && m_tready;
	assign push = valid_s1;
	assign occ  = fcnt_q + 2'(valid_s1);
	assign room = (occ < 2'd2) || pop;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and read issue
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_issue = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && do_emit) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (room) begin
					rd_issue = 1'b1;
					if (rem_q == CNT_ONE) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rd_last = (rem_q == CNT_ONE);

	// Fill count and read counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rem_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_issue;
			if (in_acc) begin
				if (do_emit) begin
					fill_q <= '0;
					rem_q  <= n_new;
				end else begin
					fill_q <= n_new;
				end
			end else if (rd_issue) begin
				rem_q <= rem_q - CNT_ONE;
			end
		end
	end

	// Read address, direction and flags of the read in flight
	always_ff @(posedge clk) begin
		if (in_acc && do_emit) begin
			rev_q   <= (n_new >= k_eff);
			final_q <= s_tlast;
			addr_q  <= (n_new >= k_eff) ? fill_q[AW-1:0] : '0;
		end else if (rd_issue) begin
			addr_q  <= rev_q ? (addr_q - AW'(1)) : (addr_q + AW'(1));
		end
		if (rd_issue) begin
			run_end_s1 <= rd_last;
			seq_end_s1 <= rd_last && final_q;
		end
	end

	// Group store
	rig_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_GROUP)
	) u_store (
		.clk   (clk),
		.we    (in_acc),
		.waddr (fill_q[AW-1:0]),
		.wdata (s_tdata),
		.re    (rd_issue),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// Output queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fcnt_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fcnt_q <= fcnt_q + 2'd1;
			end else if (pop && !push) begin
				fcnt_q <= fcnt_q - 2'd1;
			end
		end
	end

	// Output queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{value: rdata, run_end: run_end_s1, seq_end: seq_end_s1};
		end
	end

	// Drive the output port from the queue head
	assign head     = fifo_q[rd_ptr_q];
	assign m_tvalid = (fcnt_q != 2'd0);
	assign m_tdata  = head.value;
	assign m_tuser  = head.run_end;
	assign m_tlast  = head.seq_end;

`ifndef SYNTHESIS
	// The queue plus the read in flight never exceed two entries
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		!(fcnt_q == 2'd2 && valid_s1))
		else $error("output queue overrun");

	// The store is empty while a group or tail is read out
	a_fill_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (fill_q == '0))
		else $error("store filled during read-out");

	// The fill count stays below the store depth
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CNT_W'(MAX_GROUP))
		else $error("fill count out of range");

	// A sequence end is always the last result of its request
	a_seq_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser)
		else $error("sequence end without run end");
`endif

endmodule

// ===== rtl/rig_ram.sv =====
// ----------------------------------------------------------------------------
// rig_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rig_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
